>>> rtl/tsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types and constants of the touch sample filter: transfer payloads,
// configuration register indexes and the report codes.
// ----------------------------------------------------------------------------
package tsf_pkg;

   localparam int unsigned READING_BITS_DEF = 12;
   localparam int unsigned WORD_W           = 24;
   localparam int unsigned OUT_W            = 12;
   localparam int unsigned TOL_W            = 12;
   localparam int unsigned CSR_IDX_W        = 2;
   localparam int unsigned CSR_DATA_W       = 12;
   localparam int unsigned M1_LIMIT         = 400;
   localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(300);

   localparam logic [CSR_IDX_W-1:0] CSR_CHIP_MODEL = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      KIND_DISCARD = 2'd0,
      KIND_TOUCH   = 2'd1,
      KIND_RELEASE = 2'd2
   } report_kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] sample_word0;
      logic [WORD_W-1:0] sample_word1;
      logic [WORD_W-1:0] sample_word2;
      logic [WORD_W-1:0] sample_word3;
   } req_type;

   typedef struct packed {
      report_kind_type   report_kind;
      logic [OUT_W-1:0]  pos_x;
      logic [OUT_W-1:0]  pos_y;
      logic [OUT_W-1:0]  pressure;
      logic              touching;
      logic              rearm_poll;
   } rsp_type;

   typedef struct packed {
      logic             chip_model;
      logic [TOL_W-1:0] tolerance;
   } cfg_type;

endpackage
`default_nettype wire

>>> rtl/tsf_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_csr
// Configuration registers: chip model select and axis spread tolerance.
// ----------------------------------------------------------------------------
module tsf_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [tsf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tsf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output      tsf_pkg::cfg_type                 cfg
);
   import tsf_pkg::*;

   logic             chip_model_ff, chip_model_in;
   logic [TOL_W-1:0] tolerance_ff, tolerance_in;
   logic             wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   always_comb begin
      chip_model_in = chip_model_ff;
      tolerance_in  = tolerance_ff;
      if (wr_en) begin
         case (csr_index)
            CSR_CHIP_MODEL: chip_model_in = csr_wdata[0];
            CSR_TOLERANCE:  tolerance_in  = TOL_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_model_ff <= 1'b0;
         tolerance_ff  <= TOL_RESET;
      end else begin
         chip_model_ff <= chip_model_in;
         tolerance_ff  <= tolerance_in;
      end
   end

   assign cfg.chip_model = chip_model_ff;
   assign cfg.tolerance  = tolerance_ff;

   // writes to unused indexes leave both registers alone
   a_unused_index_ignored: assert property (@(posedge clock) disable iff (reset)
      (wr_en && csr_index != CSR_CHIP_MODEL && csr_index != CSR_TOLERANCE)
      |=> $stable(cfg))
      else $error("csr write to unused index changed configuration");

   a_tolerance_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && csr_index == CSR_TOLERANCE) |=> cfg.tolerance == $past(csr_wdata))
      else $error("tolerance write not taken");

endmodule
`default_nettype wire

>>> rtl/tsf_median3.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_median3
// Three-input sorting network: minimum, median and maximum of three readings.
// ----------------------------------------------------------------------------
module tsf_median3 #(
   parameter int unsigned W = tsf_pkg::READING_BITS_DEF
) (
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   input  wire logic [W-1:0] c,
   output      logic [W-1:0] lo,
   output      logic [W-1:0] mid,
   output      logic [W-1:0] hi
);
   logic [W-1:0] min_ab, max_ab, min_c;

   always_comb begin
      min_ab = (a > b) ? b : a;
      max_ab = (a > b) ? a : b;
      min_c  = (max_ab > c) ? c : max_ab;
      hi     = (max_ab > c) ? max_ab : c;
      lo     = (min_ab > min_c) ? min_c : min_ab;
      mid    = (min_ab > min_c) ? min_ab : min_c;
   end

endmodule
`default_nettype wire

>>> rtl/tsf_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_filter
// Unpacks one conversion, forms median or average position, checks the axis
// spread against the tolerance and builds the touch, release or discard report.
// ----------------------------------------------------------------------------
module tsf_filter #(
   parameter int unsigned READING_BITS = tsf_pkg::READING_BITS_DEF
) (
   input  wire tsf_pkg::req_type  req,
   input  wire tsf_pkg::cfg_type  cfg,
   output      tsf_pkg::rsp_type  rsp
);
   import tsf_pkg::*;

   localparam int unsigned RB = READING_BITS;
   localparam int unsigned CW = (RB > OUT_W) ? RB : OUT_W;
   localparam int unsigned PW = ((RB + 1) > OUT_W) ? (RB + 1) : OUT_W;

   logic [RB-1:0] xa, xb, xc, ya, yb, yc, ra, rb;
   logic [RB-1:0] x_lo, x_mid, x_hi, y_lo, y_mid, y_hi;
   logic [RB:0]   r_sum, x_sum, y_sum;
   logic [RB-1:0] mean_raw, mean, x_avg, y_avg;
   logic [RB-1:0] sx, sy, px, py;
   logic [PW-1:0] pr;
   logic          spread_ok, ok;

   assign xa = req.sample_word0[RB-1:0];
   assign xb = req.sample_word1[RB-1:0];
   assign xc = req.sample_word2[RB-1:0];
   assign ya = req.sample_word3[RB-1:0];
   assign yb = RB'(req.sample_word0 >> RB);
   assign yc = RB'(req.sample_word1 >> RB);
   assign ra = RB'(req.sample_word2 >> RB);
   assign rb = RB'(req.sample_word3 >> RB);

   tsf_median3 #(.W(RB)) u_med_x (
      .a(xa), .b(xb), .c(xc), .lo(x_lo), .mid(x_mid), .hi(x_hi)
   );

   tsf_median3 #(.W(RB)) u_med_y (
      .a(ya), .b(yb), .c(yc), .lo(y_lo), .mid(y_mid), .hi(y_hi)
   );

   always_comb begin
      r_sum    = {1'b0, ra} + {1'b0, rb};
      x_sum    = {1'b0, xa} + {1'b0, xb};
      y_sum    = {1'b0, ya} + {1'b0, yb};
      mean_raw = r_sum[RB:1];
      x_avg    = x_sum[RB:1];
      y_avg    = y_sum[RB:1];

      if (!cfg.chip_model) begin
         mean = mean_raw;
         sx   = x_hi - x_lo;
         sy   = y_hi - y_lo;
         px   = x_mid;
         py   = y_mid;
         pr   = (PW'(1) << RB) - PW'(mean);
      end else begin
         // above the limit the contact counts as released
         mean = (CW'(mean_raw) > CW'(M1_LIMIT)) ? '0 : mean_raw;
         sx   = (xa > xb) ? (xa - xb) : (xb - xa);
         sy   = (ya > yb) ? (ya - yb) : (yb - ya);
         px   = x_avg;
         py   = y_avg;
         pr   = PW'(M1_LIMIT) - PW'(mean);
      end

      spread_ok = (CW'(sx) < CW'(cfg.tolerance)) && (CW'(sy) < CW'(cfg.tolerance));
      ok        = (mean == '0) || (cfg.tolerance == '0) || spread_ok;

      rsp = '0;
      if (ok) begin
         if (mean != '0) begin
            rsp.report_kind = KIND_TOUCH;
            rsp.pos_x       = OUT_W'(px);
            rsp.pos_y       = OUT_W'(py);
            rsp.pressure    = pr[OUT_W-1:0];
            rsp.touching    = 1'b1;
            rsp.rearm_poll  = 1'b1;
         end else begin
            rsp.report_kind = KIND_RELEASE;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/touch_sample_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_sample_filter_top
// Touchscreen conversion filter: median-of-three or two-sample average,
// spread rejection, release detection and pressure inversion.
//
//   channel  ports                                   transfer when
//   -------  --------------------------------------  -------------------------
//   request  start, busy, req_data                   start && !busy
//   result   rsp_valid, rsp_data                     rsp_valid (one cycle)
//   config   csr_valid, csr_ready, csr_index,        csr_valid && csr_ready
//            csr_wdata
//
// One conversion per cycle. A request taken at one edge is captured in the
// input register; its report is in the result register after the next edge
// and is shown with rsp_valid for that single cycle.
// Latency is set by these two registers; the filter between them is one pass.
// busy follows the synchronous reset; csr_ready is always high.
// The receiver cannot stall, so nothing is held back on the result side.
// ----------------------------------------------------------------------------
module touch_sample_filter_top #(
   parameter int unsigned READING_BITS = tsf_pkg::READING_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output      logic                             busy,
   input  wire tsf_pkg::req_type                 req_data,
   output      logic                             rsp_valid,
   output      tsf_pkg::rsp_type                 rsp_data,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [tsf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tsf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tsf_pkg::*;

   cfg_type cfg;
   req_type req_data_ff, req_data_in;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    accept;

   assign busy   = reset;
   assign accept = start && !busy;

   tsf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tsf_filter #(.READING_BITS(READING_BITS)) u_filter (
      .req (req_data_ff),
      .cfg (cfg),
      .rsp (rsp_data_in)
   );

   assign req_valid_in = accept;
   assign req_data_in  = accept ? req_data : req_data_ff;
   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every report traces back to a request taken into the input register and then the result register
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a matching request");

   a_touch_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.touching == (rsp_data.report_kind == KIND_TOUCH)) &&
                    (rsp_data.rearm_poll == rsp_data.touching))
      else $error("touch flags disagree with report kind");

   a_non_touch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.report_kind != KIND_TOUCH) |->
         (rsp_data.pos_x == '0 && rsp_data.pos_y == '0 && rsp_data.pressure == '0))
      else $error("non-touch report carries position or pressure");

endmodule
`default_nettype wire

>>> tb/tb_touch_sample_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_sample_filter_top
// Drives touch conversions into the filter and predicts each report with an
// independent filter model that tracks the chip model and tolerance
// registers. Directed cases cover both filter modes, the tolerance
// boundaries, release detection and register decoding. A random sweep then
// runs each idle pattern over several register settings.
// ----------------------------------------------------------------------------
module tb_touch_sample_filter_top;
   import tsf_pkg::*;

   localparam int unsigned RB         = READING_BITS_DEF;
   localparam int unsigned FULL_SCALE = 1 << RB;
   localparam int unsigned RD_MAX     = FULL_SCALE - 1;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned SWEEP_ITEMS = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = CSR_IDX_W'(3);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // register copies seen by the predictor
   logic              chip_model_q = 1'b0;
   logic [TOL_W-1:0]  tolerance_q  = TOL_RESET;

   rsp_type     pending_reports[$];
   int unsigned idle_pct      = 0;
   int unsigned fail_count    = 0;
   int unsigned touch_count   = 0;
   int unsigned release_count = 0;
   int unsigned discard_count = 0;
   int unsigned csr_writes    = 0;
   int unsigned quiet_cycles  = 0;

   touch_sample_filter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned median3(int unsigned a, int unsigned b, int unsigned c);
      if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
      if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
      return c;
   endfunction

   function automatic int unsigned span3(int unsigned a, int unsigned b, int unsigned c);
      int unsigned hi;
      int unsigned lo;
      hi = (a > b) ? a : b;
      hi = (hi > c) ? hi : c;
      lo = (a < b) ? a : b;
      lo = (lo < c) ? lo : c;
      return hi - lo;
   endfunction

   function automatic rsp_type predict_report(req_type s, logic model, logic [TOL_W-1:0] tol);
      int unsigned xa, xb, xc, ya, yb, yc, mean, spread_x, spread_y, px, py, level;
      rsp_type r;
      xa   = s.sample_word0[RB-1:0];
      yb   = s.sample_word0[2*RB-1:RB];
      xb   = s.sample_word1[RB-1:0];
      yc   = s.sample_word1[2*RB-1:RB];
      xc   = s.sample_word2[RB-1:0];
      ya   = s.sample_word3[RB-1:0];
      mean = s.sample_word2[2*RB-1:RB];
      mean = (mean + s.sample_word3[2*RB-1:RB]) >> 1;
      if (model == 1'b0) begin
         spread_x = span3(xa, xb, xc);
         spread_y = span3(ya, yb, yc);
         px       = median3(xa, xb, xc);
         py       = median3(ya, yb, yc);
         level    = FULL_SCALE - mean;
      end else begin
         // high contact resistance counts as lifted finger
         if (mean > M1_LIMIT) mean = 0;
         spread_x = (xa > xb) ? xa - xb : xb - xa;
         spread_y = (ya > yb) ? ya - yb : yb - ya;
         px       = (xa + xb) >> 1;
         py       = (ya + yb) >> 1;
         level    = M1_LIMIT - mean;
      end
      r = '0;
      if (mean == 0) begin
         r.report_kind = KIND_RELEASE;
      end else if (tol == 0 || (spread_x < tol && spread_y < tol)) begin
         r.report_kind = KIND_TOUCH;
         r.pos_x       = OUT_W'(px);
         r.pos_y       = OUT_W'(py);
         r.pressure    = OUT_W'(level);
         r.touching    = 1'b1;
         r.rearm_poll  = 1'b1;
      end else begin
         r.report_kind = KIND_DISCARD;
      end
      return r;
   endfunction

   function automatic req_type pack_sample(int unsigned xa, int unsigned xb, int unsigned xc,
                                           int unsigned ya, int unsigned yb, int unsigned yc,
                                           int unsigned ra, int unsigned rb);
      req_type s;
      s.sample_word0 = {RB'(yb), RB'(xa)};
      s.sample_word1 = {RB'(yc), RB'(xb)};
      s.sample_word2 = {RB'(ra), RB'(xc)};
      s.sample_word3 = {RB'(rb), RB'(ya)};
      return s;
   endfunction

   function automatic int unsigned near(int unsigned center, int unsigned span);
      int v;
      v = int'(center) + int'($urandom_range(span)) - int'(span / 2);
      if (v < 0) v = 0;
      else if (v > int'(RD_MAX)) v = RD_MAX;
      return v;
   endfunction

   function automatic req_type random_sample();
      int unsigned pick, span, d, base, cx, cy, ra, rb, tmp;
      int unsigned x[3];
      int unsigned y[3];
      req_type s;
      pick = $urandom_range(99);
      span = (tolerance_q == 0) ? RD_MAX : tolerance_q * 3 / 2 + 2;
      if (span > RD_MAX) span = RD_MAX;
      cx = $urandom_range(RD_MAX);
      cy = $urandom_range(RD_MAX);
      for (int i = 0; i < 3; i++) begin
         x[i] = near(cx, span);
         y[i] = near(cy, span);
      end
      case ($urandom_range(3))
         0: ra = $urandom_range(800, 1);
         1: ra = $urandom_range(410, 390);
         2: ra = $urandom_range(RD_MAX);
         default: ra = $urandom_range(RD_MAX, RD_MAX - 95);
      endcase
      rb = near(ra, 8);
      if (pick < 12) begin
         // resistance mean rounds down to zero
         ra = $urandom_range(1);
         rb = 0;
      end else if (pick < 30) begin
         // spread placed exactly on or just below the tolerance
         d = (tolerance_q == 0) ? $urandom_range(RD_MAX) : tolerance_q - $urandom_range(1);
         base = $urandom_range(RD_MAX - d);
         if ($urandom_range(1)) begin
            x[0] = base; x[1] = base + d; x[2] = base + $urandom_range(d);
         end else begin
            y[0] = base; y[1] = base + d; y[2] = base + $urandom_range(d);
         end
         if ($urandom_range(1)) begin
            tmp = x[0]; x[0] = x[1]; x[1] = tmp;
            tmp = y[0]; y[0] = y[1]; y[1] = tmp;
         end
      end
      s = pack_sample(x[0], x[1], x[2], y[0], y[1], y[2], ra, rb);
      if (pick >= 80) begin
         s.sample_word0 = WORD_W'($urandom);
         s.sample_word1 = WORD_W'($urandom);
         s.sample_word2 = WORD_W'($urandom);
         s.sample_word3 = WORD_W'($urandom);
      end
      return s;
   endfunction

   task automatic send_sample(input req_type item);
      rsp_type want;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      want = predict_report(item, chip_model_q, tolerance_q);
      pending_reports.push_back(want);
      case (want.report_kind)
         KIND_TOUCH:   touch_count++;
         KIND_RELEASE: release_count++;
         default:      discard_count++;
      endcase
   endtask

   // stop sending and wait until every report is back
   task automatic settle_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      settle_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_CHIP_MODEL) chip_model_q = data[0];
      else if (idx == CSR_TOLERANCE) tolerance_q = data[TOL_W-1:0];
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_median_filter();
      // reset settings: median of three, tolerance 300
      send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0, 0));
      send_sample(pack_sample(100, 105, 102, 200, 210, 205, 50, 52));
      send_sample(pack_sample(1000, 1300, 1100, 500, 510, 505, 80, 90));
      send_sample(pack_sample(600, 610, 605, 1000, 1299, 1100, 80, 90));
      send_sample(pack_sample(0, RD_MAX, 2000, 0, RD_MAX, 9, 0, 0));
      send_sample(pack_sample(10, 11, 12, 20, 21, 22, 1, 0));
      send_sample('1);
      write_register(CSR_TOLERANCE, 0);
      send_sample(pack_sample(0, RD_MAX, 17, RD_MAX, 0, 3000, 700, 9));
      write_register(CSR_TOLERANCE, CSR_DATA_W'(RD_MAX));
      send_sample(pack_sample(0, RD_MAX, 17, 5, 6, 7, 700, 9));
      send_sample(pack_sample(0, RD_MAX - 1, 17, 1, 2, 3, 700, 9));
      write_register(CSR_TOLERANCE, 1);
      send_sample(pack_sample(7, 7, 7, 9, 9, 9, 3, 3));
      send_sample(pack_sample(7, 8, 7, 9, 9, 9, 3, 3));
   endtask

   task automatic test_average_filter();
      write_register(CSR_TOLERANCE, CSR_DATA_W'(TOL_RESET));
      // only bit 0 of the chip model write counts
      write_register(CSR_CHIP_MODEL, '1);
      send_sample(pack_sample(100, 101, 0, 50, 53, RD_MAX, 400, 400));
      send_sample(pack_sample(100, 101, 0, 50, 53, 0, 400, 402));
      send_sample(pack_sample(100, 101, 0, 50, 53, 0, RD_MAX, RD_MAX));
      send_sample(pack_sample(100, 400, 100, 50, 50, 50, 200, 200));
      send_sample(pack_sample(2000, 2001, 0, 3000, 3002, RD_MAX, 1, 2));
      send_sample('1);
   endtask

   task automatic test_register_decode();
      write_register(CSR_UNUSED_A, '0);
      write_register(CSR_UNUSED_B, '1);
      // touch if average mode and tolerance 300 survived; median mode at 300 discards
      send_sample(pack_sample(100, 399, 0, 50, 50, 0, 200, 200));
      write_register(CSR_CHIP_MODEL, CSR_DATA_W'('hffe));
      send_sample(pack_sample(100, 105, 102, 200, 210, 205, 50, 52));
   endtask

   task automatic test_random_sweep();
      logic [CSR_DATA_W-1:0] model_word;
      logic [CSR_DATA_W-1:0] tol_word;
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 23 : (phase == 1) ? 53 : 0;
         for (int k = 0; k < 6; k++) begin
            model_word    = CSR_DATA_W'($urandom);
            model_word[0] = k[0];
            case (k / 2)
               0: tol_word = CSR_DATA_W'($urandom_range(600, 100));
               1: tol_word = (phase == 0) ? '0 : (phase == 1) ? CSR_DATA_W'(RD_MAX) : 1;
               default: tol_word = CSR_DATA_W'($urandom_range(RD_MAX));
            endcase
            write_register(CSR_CHIP_MODEL, model_word);
            write_register(CSR_TOLERANCE, tol_word);
            for (int n = 0; n < SWEEP_ITEMS; n++) send_sample(random_sample());
         end
      end
      idle_pct = 0;
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_reports.size() == 0) begin
            $error("report with none pending: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (^rsp_data === 1'bx) begin
               $error("report carries unknown bits: %p", rsp_data);
               fail_count++;
            end
            check_field("report_kind", want.report_kind, rsp_data.report_kind);
            check_field("pos_x", want.pos_x, rsp_data.pos_x);
            check_field("pos_y", want.pos_y, rsp_data.pos_y);
            check_field("pressure", want.pressure, rsp_data.pressure);
            check_field("touching", want.touching, rsp_data.touching);
            check_field("rearm_poll", want.rearm_poll, rsp_data.rearm_poll);
         end
      end
   end

   // watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_median_filter();
      test_average_filter();
      test_register_decode();
      test_random_sweep();
      settle_idle();
      repeat (8) @(posedge clock);
      $display("conversions: %0d touch, %0d release, %0d discarded; %0d register writes",
               touch_count, release_count, discard_count, csr_writes);
      $display("both filter modes, tolerance 0/1/300/4095, three sender idle patterns");
      if (fail_count == 0 && pending_reports.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d reports missing", fail_count, pending_reports.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
